>>> rtl/hmse_pkg.sv
// hmse_pkg: shared types, sizes and state codes for the hybrid merge sort engine
// no dependencies; used by hmse_core, hybrid_merge_sort_engine and hmse_chk
`default_nettype none

package hmse_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int CUT_W     = 9;
    localparam int RUN_W     = CUT_W;
    localparam int SUM_W     = CUT_W + 1;

    localparam logic [CUT_W-1:0] CUT_RESET = CUT_W'(256);
    localparam logic [CUT_W-1:0] CUT_MIN   = CUT_W'(2);

    typedef logic signed [KEY_WIDTH-1:0] t_key;
    typedef logic [ADDR_W-1:0]           t_addr;
    typedef logic [CNT_W-1:0]            t_cnt;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_key  wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_ram_req;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RUN,
        S_IFETCH,
        S_IGET,
        S_ICMP,
        S_IPUT,
        S_MSET,
        S_MSEG,
        S_MRD,
        S_MCMP,
        S_ORD,
        S_OVAL
    } t_state;

endpackage

`default_nettype wire

>>> rtl/hmse_ram.sv
// hmse_ram: generic one-write two-read memory with registered read data
// no dependencies
`default_nettype none

module hmse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

>>> rtl/hmse_core.sv
// hmse_core: load, insertion runs, bottom-up merge passes and readout sequencer
// with the shared signed key comparator; depends on hmse_pkg
`default_nettype none

module hmse_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [hmse_pkg::RUN_W-1:0] i_run_len,
    input  wire logic                       i_in_valid,
    input  wire hmse_pkg::t_key             i_in_key,
    input  wire logic                       i_in_last,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output hmse_pkg::t_key                  o_out_key,
    output logic                            o_out_last,
    output hmse_pkg::t_ram_req              o_key_req,
    input  wire hmse_pkg::t_key             i_key_rd_a,
    input  wire hmse_pkg::t_key             i_key_rd_b,
    output hmse_pkg::t_ram_req              o_scr_req,
    input  wire hmse_pkg::t_key             i_scr_rd_a,
    input  wire hmse_pkg::t_key             i_scr_rd_b
);

    localparam int CW = hmse_pkg::CNT_W;
    localparam int AW = hmse_pkg::ADDR_W;
    localparam int SW = hmse_pkg::SUM_W;
    localparam int RW = hmse_pkg::RUN_W;

    hmse_pkg::t_state r_state, n_state;
    hmse_pkg::t_cnt   r_count, n_count;
    hmse_pkg::t_cnt   r_lo, n_lo;
    hmse_pkg::t_cnt   r_hi, n_hi;
    hmse_pkg::t_cnt   r_mid, n_mid;
    hmse_pkg::t_cnt   r_i, n_i;
    hmse_pkg::t_cnt   r_j, n_j;
    hmse_pkg::t_cnt   r_a, n_a;
    hmse_pkg::t_cnt   r_b, n_b;
    hmse_pkg::t_cnt   r_k, n_k;
    logic [RW-1:0]    r_w, n_w;
    hmse_pkg::t_key   r_x, n_x;
    logic             r_src_scr, n_src_scr;

    logic [SW-1:0]    sum_run, sum_mid, sum_hi, w2, n_ext;
    hmse_pkg::t_cnt   run_hi, seg_mid, seg_hi, i_inc, j_dec;
    hmse_pkg::t_key   src_a, src_b, cmp_l, cmp_r, mdata;
    logic             less, take_a;
    hmse_pkg::t_ram_req dst_req;

    always_comb begin
        n_ext   = SW'(r_count);
        sum_run = SW'(r_lo) + SW'(i_run_len);
        sum_mid = SW'(r_lo) + SW'(r_w);
        w2      = SW'(r_w) << 1;
        sum_hi  = SW'(r_lo) + w2;
        run_hi  = (sum_run >= n_ext) ? r_count : sum_run[CW-1:0];
        seg_mid = (sum_mid >= n_ext) ? r_count : sum_mid[CW-1:0];
        seg_hi  = (sum_hi >= n_ext) ? r_count : sum_hi[CW-1:0];
        i_inc   = r_i + CW'(1);
        j_dec   = r_j - CW'(1);
        src_a   = r_src_scr ? i_scr_rd_a : i_key_rd_a;
        src_b   = r_src_scr ? i_scr_rd_b : i_key_rd_b;
        // shared comparator, operands follow the phase
        cmp_l   = (r_state == hmse_pkg::S_ICMP) ? r_x : src_a;
        cmp_r   = (r_state == hmse_pkg::S_ICMP) ? i_key_rd_a : src_b;
        less    = cmp_l < cmp_r;
        take_a  = (r_a < r_mid) && ((r_b >= r_hi) || less);
        mdata   = take_a ? src_a : src_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hmse_pkg::S_LOAD;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_i       <= n_i;
        r_j       <= n_j;
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_w       <= n_w;
        r_x       <= n_x;
        r_src_scr <= n_src_scr;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_w         = r_w;
        n_x         = r_x;
        n_src_scr   = r_src_scr;
        o_key_req   = '0;
        o_scr_req   = '0;
        dst_req     = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        o_out_key   = src_a;

        unique case (r_state)
            hmse_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_count < CW'(hmse_pkg::MAX_KEYS)) begin
                        o_key_req.we    = 1'b1;
                        o_key_req.waddr = r_count[AW-1:0];
                        o_key_req.wdata = i_in_key;
                        n_count         = r_count + CW'(1);
                    end
                    if (i_in_last) begin
                        n_lo    = '0;
                        n_state = hmse_pkg::S_RUN;
                    end
                end
            end
            hmse_pkg::S_RUN: begin
                if (r_lo >= r_count) begin
                    n_state = hmse_pkg::S_MSET;
                end else begin
                    n_hi    = run_hi;
                    n_i     = r_lo + CW'(1);
                    n_state = hmse_pkg::S_IFETCH;
                end
            end
            hmse_pkg::S_IFETCH: begin
                if (r_i >= r_hi) begin
                    n_lo    = r_hi;
                    n_state = hmse_pkg::S_RUN;
                end else begin
                    o_key_req.raddr_a = r_i[AW-1:0];
                    n_j               = r_i;
                    n_state           = hmse_pkg::S_IGET;
                end
            end
            hmse_pkg::S_IGET: begin
                n_x               = i_key_rd_a;
                o_key_req.raddr_a = j_dec[AW-1:0];
                n_state           = hmse_pkg::S_ICMP;
            end
            hmse_pkg::S_ICMP: begin
                o_key_req.we    = 1'b1;
                o_key_req.waddr = r_j[AW-1:0];
                if (less) begin
                    o_key_req.wdata = i_key_rd_a;
                    n_j             = j_dec;
                    if (j_dec > r_lo) begin
                        o_key_req.raddr_a = AW'(j_dec - CW'(1));
                    end else begin
                        n_state = hmse_pkg::S_IPUT;
                    end
                end else begin
                    o_key_req.wdata = r_x;
                    n_i             = i_inc;
                    n_state         = hmse_pkg::S_IFETCH;
                end
            end
            hmse_pkg::S_IPUT: begin
                o_key_req.we    = 1'b1;
                o_key_req.waddr = r_j[AW-1:0];
                o_key_req.wdata = r_x;
                n_i             = i_inc;
                n_state         = hmse_pkg::S_IFETCH;
            end
            hmse_pkg::S_MSET: begin
                n_w       = i_run_len;
                n_lo      = '0;
                n_src_scr = 1'b0;
                n_i       = '0;
                if (SW'(i_run_len) >= n_ext) begin
                    n_state = hmse_pkg::S_ORD;
                end else begin
                    n_state = hmse_pkg::S_MSEG;
                end
            end
            hmse_pkg::S_MSEG: begin
                if (r_lo >= r_count) begin
                    n_w       = w2[RW-1:0];
                    n_src_scr = !r_src_scr;
                    n_lo      = '0;
                    n_i       = '0;
                    if (w2 >= n_ext) begin
                        n_state = hmse_pkg::S_ORD;
                    end
                end else begin
                    n_mid   = seg_mid;
                    n_hi    = seg_hi;
                    n_a     = r_lo;
                    n_b     = seg_mid;
                    n_k     = r_lo;
                    n_state = hmse_pkg::S_MRD;
                end
            end
            hmse_pkg::S_MRD: begin
                if (r_src_scr) begin
                    o_scr_req.raddr_a = r_a[AW-1:0];
                    o_scr_req.raddr_b = r_b[AW-1:0];
                end else begin
                    o_key_req.raddr_a = r_a[AW-1:0];
                    o_key_req.raddr_b = r_b[AW-1:0];
                end
                n_state = hmse_pkg::S_MCMP;
            end
            hmse_pkg::S_MCMP: begin
                dst_req.we    = 1'b1;
                dst_req.waddr = r_k[AW-1:0];
                dst_req.wdata = mdata;
                if (r_src_scr) begin
                    o_key_req = dst_req;
                end else begin
                    o_scr_req = dst_req;
                end
                if (take_a) begin
                    n_a = r_a + CW'(1);
                end else begin
                    n_b = r_b + CW'(1);
                end
                n_k = r_k + CW'(1);
                if (r_k + CW'(1) >= r_hi) begin
                    n_lo    = r_hi;
                    n_state = hmse_pkg::S_MSEG;
                end else begin
                    n_state = hmse_pkg::S_MRD;
                end
            end
            hmse_pkg::S_ORD: begin
                o_key_req.raddr_a = r_i[AW-1:0];
                o_scr_req.raddr_a = r_i[AW-1:0];
                n_state           = hmse_pkg::S_OVAL;
            end
            hmse_pkg::S_OVAL: begin
                // hold the read address so the registered read data stays put
                o_key_req.raddr_a = r_i[AW-1:0];
                o_scr_req.raddr_a = r_i[AW-1:0];
                o_out_valid       = 1'b1;
                o_out_last        = (i_inc == r_count);
                if (i_out_ready) begin
                    if (i_inc == r_count) begin
                        n_count = '0;
                        n_state = hmse_pkg::S_LOAD;
                    end else begin
                        n_i     = i_inc;
                        n_state = hmse_pkg::S_ORD;
                    end
                end
            end
            default: begin
                n_state = hmse_pkg::S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/hybrid_merge_sort_engine.sv
// hybrid_merge_sort_engine: top level with cutoff register, key and scratch stores
// depends on hmse_pkg, hmse_ram, hmse_core
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[31:0] key, tlast last_in
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[31:0] sorted_key, tlast last_out
// cfg       in   i_cfg_we                       i_cfg_wdata insertion_cutoff
//
// load: one key per cycle while ready; the tlast key starts the sort
// insertion runs of up to cutoff-1 keys (one key if cutoff is below 2)
// merge passes: ceil(log2(n/run)) passes, alternating key and scratch stores
// readout: each key is read, then held until m_axis_tready takes it
// input ready is low from the tlast transfer until the last result transfer
// reset clears the sequencer, key count and cutoff (256); stores need no clearing
`default_nettype none

module hybrid_merge_sort_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hmse_pkg::CUT_W-1:0]  i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,  // [31:0] key
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [31:0]                 m_axis_tdata,  // [31:0] sorted_key
    output logic                             m_axis_tlast
);

    logic [hmse_pkg::CUT_W-1:0] r_cut;
    logic [hmse_pkg::RUN_W-1:0] run_len;
    hmse_pkg::t_ram_req         key_req, scr_req;
    hmse_pkg::t_key             key_rd_a, key_rd_b, scr_rd_a, scr_rd_b;
    hmse_pkg::t_key             out_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= hmse_pkg::CUT_RESET;
        end else if (i_cfg_we) begin
            r_cut <= i_cfg_wdata;
        end
    end

    // run length is the longest segment that still takes insertion
    assign run_len = (r_cut < hmse_pkg::CUT_MIN) ? hmse_pkg::RUN_W'(1)
                                                  : hmse_pkg::RUN_W'(r_cut - 1'b1);

    hmse_ram #(
        .WIDTH (hmse_pkg::KEY_WIDTH),
        .DEPTH (hmse_pkg::MAX_KEYS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_req.we),
        .i_waddr   (key_req.waddr),
        .i_wdata   (key_req.wdata),
        .i_raddr_a (key_req.raddr_a),
        .i_raddr_b (key_req.raddr_b),
        .o_rdata_a (key_rd_a),
        .o_rdata_b (key_rd_b)
    );

    hmse_ram #(
        .WIDTH (hmse_pkg::KEY_WIDTH),
        .DEPTH (hmse_pkg::MAX_KEYS)
    ) u_scr_ram (
        .i_clk     (i_clk),
        .i_we      (scr_req.we),
        .i_waddr   (scr_req.waddr),
        .i_wdata   (scr_req.wdata),
        .i_raddr_a (scr_req.raddr_a),
        .i_raddr_b (scr_req.raddr_b),
        .o_rdata_a (scr_rd_a),
        .o_rdata_b (scr_rd_b)
    );

    hmse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_len   (run_len),
        .i_in_valid  (s_axis_tvalid),
        .i_in_key    (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_key   (out_key),
        .o_out_last  (m_axis_tlast),
        .o_key_req   (key_req),
        .i_key_rd_a  (key_rd_a),
        .i_key_rd_b  (key_rd_b),
        .o_scr_req   (scr_req),
        .i_scr_rd_a  (scr_rd_a),
        .i_scr_rd_b  (scr_rd_b)
    );

    assign m_axis_tdata = out_key;

endmodule

`default_nettype wire

>>> rtl/hmse_chk.sv
// hmse_chk: port-level checks for hybrid_merge_sort_engine, bound to the top level
// depends on hmse_pkg and hybrid_merge_sort_engine
`default_nettype none

module hmse_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_cfg_we,
    input wire logic [hmse_pkg::CUT_W-1:0] i_cfg_wdata,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic [31:0]                s_axis_tdata,
    input wire logic                       s_axis_tlast,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [31:0]                m_axis_tdata,
    input wire logic                       m_axis_tlast
);

    // input side and output side never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is shown");

    // last input transfer closes the input until results are done
    a_last_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after last key");

    // last result transfer reopens the input
    a_last_out_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !m_axis_tvalid))
        else $error("input not reopened after last result");

    // a shown result holds until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

    // out of reset the block waits for keys
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid || !i_rst_n))
        else $error("result shown right after reset");

endmodule

bind hybrid_merge_sort_engine hmse_chk u_hmse_chk (.*);

`default_nettype wire
